>>> rtl/core/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types, constants and helpers for the LSB payload extractor.
// ----------------------------------------------------------------------------
package lsbse_pkg;

	// Default geometry
	localparam int HEADER_BYTES_DEF = 54;
	localparam int MAGIC_BYTES_DEF  = 8;

	// Configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_MLEN,
		PH_MAGIC,
		PH_ELEN,
		PH_EXT,
		PH_DLEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		K_EXT      = 3'd0,
		K_DATA     = 3'd1,
		K_MATCH    = 3'd2,
		K_MISMATCH = 3'd3,
		K_EMPTY    = 3'd4
	} kind_t;

	// Decoder state carried from item to item
	typedef struct packed {
		phase_t      phase;
		logic [5:0]  skip_cnt;
		logic [4:0]  bit_idx;
		logic [31:0] acc;
		logic [31:0] bytes_left;
		logic [2:0]  magic_pos;
		logic        mismatch;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	// State at reset and at start of a new image
	function automatic state_t restart_state(input int hdr_bytes);
		state_t s;
		s            = '0;
		s.phase      = (hdr_bytes == 0) ? PH_MLEN : PH_HEADER;
		return s;
	endfunction

endpackage

>>> rtl/core/lsbse_ifs.sv
// ----------------------------------------------------------------------------
// lsbse_ifs
// Valid/ready channels of the LSB payload extractor.
// ----------------------------------------------------------------------------
interface lsbse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] carrier_byte;
	logic       start_of_image;

	modport source(output valid, carrier_byte, start_of_image, input ready);
	modport sink(input valid, carrier_byte, start_of_image, output ready);
endinterface

interface lsbse_out_if;
	logic              valid;
	logic              ready;
	lsbse_pkg::kind_t  kind;
	logic [7:0]        value;
	logic              last;

	modport source(output valid, kind, value, last, input ready);
	modport sink(input valid, kind, value, last, output ready);
endinterface

interface lsbse_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lsbse_pkg::CFG_IDX_W-1:0]   index;
	logic [63:0]                       data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/lsbse_step.sv
// ----------------------------------------------------------------------------
// lsbse_step
// Next-state and result logic for one carrier byte.
// ----------------------------------------------------------------------------
module lsbse_step #(
	parameter int HEADER_BYTES = lsbse_pkg::HEADER_BYTES_DEF,
	parameter int MAGIC_BYTES  = lsbse_pkg::MAGIC_BYTES_DEF
) (
	input  lsbse_pkg::state_t  st,
	input  logic [7:0]         carrier_byte,
	input  logic               start_of_image,
	input  logic [63:0]        magic_word,
	input  logic [3:0]         magic_length,
	output lsbse_pkg::state_t  st_nxt,
	output logic               emit,
	output lsbse_pkg::result_t res
);

	lsbse_pkg::state_t cur;
	logic [31:0] acc_sh;
	logic [4:0]  idx_inc;
	logic [5:0]  skip_inc;
	logic [31:0] left_dec;
	logic [7:0]  got8;
	logic [7:0]  want;
	logic [3:0]  exp_len;
	logic        collecting;
	logic        done;
	logic        mis_n;

	assign exp_len = (magic_length > 4'(MAGIC_BYTES)) ? 4'(MAGIC_BYTES) : magic_length;

	always_comb begin
		// Restart takes effect before this byte is decoded
		cur        = start_of_image ? lsbse_pkg::restart_state(HEADER_BYTES) : st;
		acc_sh     = {cur.acc[30:0], carrier_byte[0]};
		idx_inc    = cur.bit_idx + 5'd1;
		skip_inc   = cur.skip_cnt + 6'd1;
		left_dec   = cur.bytes_left - 32'd1;
		got8       = acc_sh[7:0];
		want       = magic_word[(7 - int'(cur.magic_pos)) * 8 +: 8];
		mis_n      = cur.mismatch | (want != got8);
		st_nxt     = cur;
		emit       = 1'b0;
		res        = '0;
		collecting = 1'b0;
		done       = 1'b0;

		unique case (cur.phase)
			lsbse_pkg::PH_HEADER: begin
				st_nxt.skip_cnt = skip_inc;
				if (skip_inc >= 6'(HEADER_BYTES))
					st_nxt.phase = lsbse_pkg::PH_MLEN;
			end
			lsbse_pkg::PH_MLEN: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd0);
				if (done) begin
					if (acc_sh != {28'd0, exp_len}) begin
						st_nxt.phase = lsbse_pkg::PH_DONE;
						emit         = 1'b1;
						res.kind     = lsbse_pkg::K_MISMATCH;
					end else if (acc_sh == 32'd0) begin
						st_nxt.phase = lsbse_pkg::PH_ELEN;
						emit         = 1'b1;
						res.kind     = lsbse_pkg::K_MATCH;
					end else begin
						st_nxt.bytes_left = acc_sh;
						st_nxt.magic_pos  = 3'd0;
						st_nxt.mismatch   = 1'b0;
						st_nxt.phase      = lsbse_pkg::PH_MAGIC;
					end
				end
			end
			lsbse_pkg::PH_MAGIC: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd8);
				if (done) begin
					st_nxt.mismatch   = mis_n;
					st_nxt.magic_pos  = cur.magic_pos + 3'd1;
					st_nxt.bytes_left = left_dec;
					if (left_dec == 32'd0) begin
						emit = 1'b1;
						if (mis_n) begin
							st_nxt.phase = lsbse_pkg::PH_DONE;
							res.kind     = lsbse_pkg::K_MISMATCH;
						end else begin
							st_nxt.phase = lsbse_pkg::PH_ELEN;
							res.kind     = lsbse_pkg::K_MATCH;
						end
					end
				end
			end
			lsbse_pkg::PH_ELEN: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd0);
				if (done) begin
					st_nxt.bytes_left = acc_sh;
					st_nxt.phase      = (acc_sh == 32'd0) ? lsbse_pkg::PH_DLEN
						: lsbse_pkg::PH_EXT;
				end
			end
			lsbse_pkg::PH_EXT: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd8);
				if (done) begin
					st_nxt.bytes_left = left_dec;
					emit              = 1'b1;
					res.kind          = lsbse_pkg::K_EXT;
					res.value         = got8;
					res.last          = (left_dec == 32'd0);
					if (left_dec == 32'd0)
						st_nxt.phase = lsbse_pkg::PH_DLEN;
				end
			end
			lsbse_pkg::PH_DLEN: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd0);
				if (done) begin
					st_nxt.bytes_left = acc_sh;
					if (acc_sh == 32'd0) begin
						st_nxt.phase = lsbse_pkg::PH_DONE;
						emit         = 1'b1;
						res.kind     = lsbse_pkg::K_EMPTY;
					end else begin
						st_nxt.phase = lsbse_pkg::PH_DATA;
					end
				end
			end
			lsbse_pkg::PH_DATA: begin
				collecting = 1'b1;
				done       = (idx_inc == 5'd8);
				if (done) begin
					st_nxt.bytes_left = left_dec;
					emit              = 1'b1;
					res.kind          = lsbse_pkg::K_DATA;
					res.value         = got8;
					res.last          = (left_dec == 32'd0);
					if (left_dec == 32'd0)
						st_nxt.phase = lsbse_pkg::PH_DONE;
				end
			end
			lsbse_pkg::PH_DONE: begin
				st_nxt.phase = lsbse_pkg::PH_DONE;
			end
		endcase

		// Bit collector: shift in the LSB, clear once a field is complete
		if (collecting) begin
			if (done) begin
				st_nxt.acc     = 32'd0;
				st_nxt.bit_idx = 5'd0;
			end else begin
				st_nxt.acc     = acc_sh;
				st_nxt.bit_idx = idx_inc;
			end
		end
	end

endmodule

>>> rtl/core/lsb_stego_payload_extractor_core.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor_core
// Extracts a length-framed payload hidden in the LSBs of carrier image bytes.
// ----------------------------------------------------------------------------
// A result is decoded from its byte in the input register and held in the result register.
// Throughput: one carrier byte per cycle unless a held result stalls; the decode
//   state updates in a single pass from the input register.
// A held result only stalls bytes that would produce another result.
// Reset (arst_n low): clears control state and config registers; decoding
//   starts in the header skip, or in the magic length field if HEADER_BYTES is 0.
module lsb_stego_payload_extractor_core #(
	parameter int HEADER_BYTES = lsbse_pkg::HEADER_BYTES_DEF,
	parameter int MAGIC_BYTES  = lsbse_pkg::MAGIC_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	lsbse_in_if.sink           carrier,
	lsbse_out_if.source        payload,
	lsbse_cfg_if.sink          cfg
);

	logic [63:0]        magic_word_q;
	logic [3:0]         magic_length_q;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               sof_s1;

	lsbse_pkg::state_t  state_q;
	lsbse_pkg::state_t  state_nxt;
	logic               emit;
	lsbse_pkg::result_t res;

	logic               out_valid_q;
	lsbse_pkg::result_t out_q;

	logic               adv_s1;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q   <= '0;
			magic_length_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lsbse_pkg::CFG_MAGIC_WORD:   magic_word_q   <= cfg.data;
				lsbse_pkg::CFG_MAGIC_LENGTH: magic_length_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Decode of the byte held in stage 1
	lsbse_step #(
		.HEADER_BYTES (HEADER_BYTES),
		.MAGIC_BYTES  (MAGIC_BYTES)
	) u_step (
		.st             (state_q),
		.carrier_byte   (byte_s1),
		.start_of_image (sof_s1),
		.magic_word     (magic_word_q),
		.magic_length   (magic_length_q),
		.st_nxt         (state_nxt),
		.emit           (emit),
		.res            (res)
	);

	// Stage 1 retires unless its result has nowhere to go
	assign adv_s1        = valid_s1 && (!emit || !out_valid_q || payload.ready);
	assign carrier.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (carrier.ready)
			valid_s1 <= carrier.valid;
	end

	always_ff @(posedge clk) begin
		if (carrier.ready && carrier.valid) begin
			byte_s1 <= carrier.carrier_byte;
			sof_s1  <= carrier.start_of_image;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lsbse_pkg::restart_state(HEADER_BYTES);
		else if (adv_s1)
			state_q <= state_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && emit)
			out_valid_q <= 1'b1;
		else if (payload.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit)
			out_q <= res;
	end

	assign payload.valid = out_valid_q;
	assign payload.kind  = out_q.kind;
	assign payload.value = out_q.value;
	assign payload.last  = out_q.last;

endmodule

>>> rtl/core/lsbse_checker.sv
// ----------------------------------------------------------------------------
// lsbse_checker
// Port-level assertions for the LSB payload extractor, bound to the core.
// ----------------------------------------------------------------------------
module lsbse_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_sof,
	input logic             out_valid,
	input logic             out_ready,
	input lsbse_pkg::kind_t out_kind,
	input logic [7:0]       out_value,
	input logic             out_last
);

	logic in_acc;
	logic out_acc;
	logic out_end;
	logic out_status;
	logic ended_q;
	logic status_q;
	logic skip_q;

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign out_status = (out_kind == lsbse_pkg::K_MATCH) ||
		(out_kind == lsbse_pkg::K_MISMATCH);
	assign out_end    = (out_kind == lsbse_pkg::K_MISMATCH) ||
		(out_kind == lsbse_pkg::K_EMPTY) ||
		((out_kind == lsbse_pkg::K_DATA) && out_last);

	// Track image state between restarts; the first item taken after a
	// restart may still belong to the previous image, so it is not tracked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q  <= 1'b0;
			status_q <= 1'b0;
			skip_q   <= 1'b0;
		end else if (in_acc && in_sof) begin
			ended_q  <= 1'b0;
			status_q <= 1'b0;
			skip_q   <= 1'b1;
		end else if (out_acc) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else begin
				if (out_end)
					ended_q <= 1'b1;
				if (out_status)
					status_q <= 1'b1;
			end
		end
	end

	// A stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
		$stable(out_value) && $stable(out_last))
		else $error("result changed while stalled");

	// Status kinds carry no byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status || (out_kind == lsbse_pkg::K_EMPTY)) |->
		(out_value == 8'd0) && !out_last)
		else $error("status item with nonzero value or last");

	// Nothing after the end of a payload or a mismatch until a restart
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !out_valid)
		else $error("item after end of image decode");

	// Magic verdict is reported at most once per image
	a_one_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		status_q && out_valid |-> !out_status)
		else $error("second magic verdict in one image");

endmodule

bind lsb_stego_payload_extractor_core lsbse_checker u_lsbse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (carrier.valid),
	.in_ready  (carrier.ready),
	.in_sof    (carrier.start_of_image),
	.out_valid (payload.valid),
	.out_ready (payload.ready),
	.out_kind  (payload.kind),
	.out_value (payload.value),
	.out_last  (payload.last)
);
